[sv/tlr_pkg.sv]
`timescale 1ns / 1ps

package tlr_pkg;

  // Longest payload a header can announce (low nibble)
  localparam int MAX_PAYLOAD = 15;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_DATA_TIMEOUT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDLE_TIMEOUT = 2'd1;

  localparam logic [15:0] DATA_TIMEOUT_RESET = 16'd100;
  localparam logic [15:0] IDLE_TIMEOUT_RESET = 16'd500;

  // Request operation codes
  typedef enum logic [2:0] {
    OP_BYTE  = 3'd0,
    OP_TICK  = 3'd1,
    OP_POP   = 3'd2,
    OP_ARM   = 3'd3,
    OP_CLEAR = 3'd4
  } op_t;

  // Deframer mode
  typedef enum logic [1:0] {
    MODE_HEADER = 2'd0,
    MODE_DATA   = 2'd1,
    MODE_IDLE   = 2'd2
  } mode_t;

  // Request sequencing: take requests, or stream out a popped packet
  typedef enum logic {
    ST_ACCEPT = 1'b0,
    ST_POP    = 1'b1
  } ctl_state_t;

endpackage

[sv/tlr_ram.sv]
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read per cycle.
// The read register only updates when rd_en is high.
module tlr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/type_length_packet_receiver_fifo_core.sv]
// Type/length packet deframer with a packet queue. Requests arrive on the
// input channel (op, rx_byte): a received byte, a millisecond tick, a pop, an
// arm of the deframer or a clear of the queue. A header byte carries the type
// in its high nibble and the payload length in its low nibble; that many
// payload bytes follow and the finished packet is queued (up to QUEUE_DEPTH
// packets; a full queue drops it and sets the sticky overload flag). Every
// request gives one result, except a pop of a packet with L > 0 payload bytes,
// which gives L results, one per byte. A new request is taken every cycle
// while the result register is free and no pop is streaming. A pop of a
// non-empty queue holds off further requests until its packet is out: its
// request reads the header and first byte, then one payload byte per cycle
// leaves the single read port of the payload RAM unless the output stalls.
// Payload bytes are written straight into the queue slot at the tail; the
// one spare slot means a packet being received never overwrites a queued one.
// No clearing pass is needed after reset. The user must write timeouts on
// the configuration channel (index 0 data timeout, index 1 idle timeout)
// only while the block is idle, which it does not enforce; cfg_ready is always high.
`timescale 1ns / 1ps

module type_length_packet_receiver_fifo_core #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    op,
  input  logic [7:0]                    rx_byte,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tlr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [3:0]                    packet_type,
  output logic [3:0]                    pkt_len,
  output logic [7:0]                    data_byte,
  output logic [3:0]                    byte_index,
  output logic                          last,
  output logic                          popped_valid,
  output logic                          pkt_available,
  output logic                          overload,
  output logic                          timeout_fired,
  output logic                          dropped
);

  import tlr_pkg::*;

  // One spare slot holds the packet being received
  localparam int SLOTS  = QUEUE_DEPTH + 1;
  localparam int SW     = $clog2(SLOTS);
  localparam int PDEPTH = SLOTS * MAX_PAYLOAD;
  localparam int PAW    = $clog2(PDEPTH);

  // Configuration
  logic [15:0] data_timeout;
  logic [15:0] idle_timeout;

  // Deframer and timer state
  mode_t       mode, mode_next;
  logic [3:0]  rx_type, rx_type_next;
  logic [3:0]  rx_length, rx_length_next;
  logic [3:0]  rx_count, rx_count_next;
  logic [3:0]  rx_count_inc;
  logic [15:0] timer_count, timer_count_next;
  logic        timer_on, timer_on_next;

  // Queue state
  logic [SW-1:0] head, head_next;
  logic [SW-1:0] tail, tail_next;
  logic [SW-1:0] qcount, qcount_next;
  logic          overload_flag, overload_flag_next;

  // Request handling
  ctl_state_t ctl, ctl_next;
  op_t        op_in;
  logic       out_free;
  logic       in_acc;
  logic       pop_start;
  logic       enq;
  logic [7:0] enq_hdr;
  logic       fired;
  logic       drop;
  logic       hdr_we;
  logic       pay_we;

  // Pop streaming
  logic [7:0]     hdr_rd;
  logic [7:0]     pay_rd;
  logic           pay_re;
  logic [PAW-1:0] pay_raddr;
  logic [PAW-1:0] pay_waddr;
  logic [PAW-1:0] pop_base;
  logic [3:0]     pop_k;
  logic           pop_avail;
  logic           pop_last;
  logic           load_gen;
  logic           load_pop;

  assign cfg_ready = 1'b1;
  assign op_in     = op_t'(op);
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (ctl == ST_ACCEPT) && out_free;
  assign in_acc    = in_valid && in_ready;
  assign pop_start = in_acc && (op_in == OP_POP) && (qcount != '0);
  assign load_gen  = in_acc && !pop_start;
  assign load_pop  = (ctl == ST_POP) && out_free;

  assign rx_count_inc = rx_count + 4'd1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      data_timeout <= DATA_TIMEOUT_RESET;
      idle_timeout <= IDLE_TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DATA_TIMEOUT: data_timeout <= cfg_data;
        CFG_IDLE_TIMEOUT: idle_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request processing: deframer, timer and queue pointers
  always_comb begin
    mode_next          = mode;
    rx_type_next       = rx_type;
    rx_length_next     = rx_length;
    rx_count_next      = rx_count;
    timer_count_next   = timer_count;
    timer_on_next      = timer_on;
    head_next          = head;
    tail_next          = tail;
    qcount_next        = qcount;
    overload_flag_next = overload_flag;
    enq                = 1'b0;
    enq_hdr            = 8'h00;
    fired              = 1'b0;
    drop               = 1'b0;
    hdr_we             = 1'b0;
    pay_we             = 1'b0;
    if (in_acc) begin
      case (op_in)
        OP_BYTE: begin
          case (mode)
            MODE_HEADER: begin
              if (rx_byte[3:0] != 4'd0) begin
                rx_type_next     = rx_byte[7:4];
                rx_length_next   = rx_byte[3:0];
                rx_count_next    = 4'd0;
                mode_next        = MODE_DATA;
                timer_count_next = data_timeout;
                timer_on_next    = 1'b1;
              end else begin
                // zero-length packet is complete at once
                enq              = 1'b1;
                enq_hdr          = {rx_byte[7:4], 4'd0};
                rx_type_next     = 4'd0;
                rx_length_next   = 4'd0;
                rx_count_next    = 4'd0;
                timer_count_next = idle_timeout;
                timer_on_next    = 1'b1;
              end
            end
            MODE_DATA: begin
              pay_we = 1'b1;
              if (rx_count_inc >= rx_length) begin
                enq              = 1'b1;
                enq_hdr          = {rx_type, rx_length};
                mode_next        = MODE_HEADER;
                rx_type_next     = 4'd0;
                rx_length_next   = 4'd0;
                rx_count_next    = 4'd0;
                timer_count_next = idle_timeout;
              end else begin
                rx_count_next    = rx_count_inc;
                timer_count_next = data_timeout;
              end
              timer_on_next = 1'b1;
            end
            default: ;
          endcase
        end
        OP_TICK: begin
          if (timer_on) begin
            if (timer_count <= 16'd1) begin
              // expiry: drop the partial packet, wait for a header
              timer_count_next = 16'd0;
              timer_on_next    = 1'b0;
              fired            = 1'b1;
              mode_next        = MODE_HEADER;
              rx_type_next     = 4'd0;
              rx_length_next   = 4'd0;
              rx_count_next    = 4'd0;
            end else begin
              timer_count_next = timer_count - 16'd1;
            end
          end
        end
        OP_POP: begin
          if (qcount != '0) begin
            qcount_next        = qcount - SW'(1);
            overload_flag_next = 1'b0;
            head_next          = (head == SW'(QUEUE_DEPTH)) ? '0 : head + SW'(1);
          end
        end
        OP_ARM: begin
          mode_next      = MODE_HEADER;
          rx_type_next   = 4'd0;
          rx_length_next = 4'd0;
          rx_count_next  = 4'd0;
        end
        OP_CLEAR: begin
          // keep the tail so a packet in reception stays in its slot
          head_next          = tail;
          qcount_next        = '0;
          overload_flag_next = 1'b0;
        end
        default: ;
      endcase
    end

    // Append a finished packet, or drop it when the queue is full
    if (enq) begin
      if (qcount >= SW'(QUEUE_DEPTH)) begin
        overload_flag_next = 1'b1;
        drop               = 1'b1;
      end else begin
        hdr_we      = 1'b1;
        qcount_next = qcount + SW'(1);
        tail_next   = (tail == SW'(QUEUE_DEPTH)) ? '0 : tail + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      rx_type       <= 4'd0;
      rx_length     <= 4'd0;
      rx_count      <= 4'd0;
      timer_count   <= 16'd0;
      timer_on      <= 1'b0;
      head          <= '0;
      tail          <= '0;
      qcount        <= '0;
      overload_flag <= 1'b0;
    end else begin
      mode          <= mode_next;
      rx_type       <= rx_type_next;
      rx_length     <= rx_length_next;
      rx_count      <= rx_count_next;
      timer_count   <= timer_count_next;
      timer_on      <= timer_on_next;
      head          <= head_next;
      tail          <= tail_next;
      qcount        <= qcount_next;
      overload_flag <= overload_flag_next;
    end
  end

  // Queue memories
  assign pay_waddr = PAW'(tail) * PAW'(MAX_PAYLOAD) + PAW'(rx_count);
  assign pay_re    = pop_start || (load_pop && !pop_last);
  assign pay_raddr = pop_start ? PAW'(head) * PAW'(MAX_PAYLOAD)
                               : pop_base + PAW'(pop_k) + PAW'(1);

  tlr_ram #(
    .WIDTH (8),
    .DEPTH (SLOTS)
  ) u_hdr_ram (
    .clk     (clk),
    .wr_en   (hdr_we),
    .wr_addr (tail),
    .wr_data (enq_hdr),
    .rd_en   (pop_start),
    .rd_addr (head),
    .rd_data (hdr_rd)
  );

  tlr_ram #(
    .WIDTH (8),
    .DEPTH (PDEPTH)
  ) u_pay_ram (
    .clk     (clk),
    .wr_en   (pay_we),
    .wr_addr (pay_waddr),
    .wr_data (rx_byte),
    .rd_en   (pay_re),
    .rd_addr (pay_raddr),
    .rd_data (pay_rd)
  );

  // Pop bookkeeping
  assign pop_last = (hdr_rd[3:0] == 4'd0) || (pop_k == hdr_rd[3:0] - 4'd1);

  always_ff @(posedge clk) begin
    if (pop_start) begin
      pop_base  <= PAW'(head) * PAW'(MAX_PAYLOAD);
      pop_k     <= 4'd0;
      pop_avail <= (qcount_next != '0);
    end else if (load_pop) begin
      pop_k <= pop_k + 4'd1;
    end
  end

  // Sequencer next state
  always_comb begin
    ctl_next = ctl;
    case (ctl)
      ST_ACCEPT: if (pop_start) ctl_next = ST_POP;
      ST_POP:    if (load_pop && pop_last) ctl_next = ST_ACCEPT;
      default:   ctl_next = ST_ACCEPT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= ST_ACCEPT;
    end else begin
      ctl <= ctl_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_gen || load_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_pop) begin
      packet_type   <= hdr_rd[7:4];
      pkt_len       <= hdr_rd[3:0];
      data_byte     <= (hdr_rd[3:0] == 4'd0) ? 8'd0 : pay_rd;
      byte_index    <= (hdr_rd[3:0] == 4'd0) ? 4'd0 : pop_k;
      last          <= pop_last;
      popped_valid  <= 1'b1;
      pkt_available <= pop_avail;
      overload      <= 1'b0;
      timeout_fired <= 1'b0;
      dropped       <= 1'b0;
    end else if (load_gen) begin
      packet_type   <= 4'd0;
      pkt_len       <= 4'd0;
      data_byte     <= 8'd0;
      byte_index    <= 4'd0;
      last          <= 1'b1;
      popped_valid  <= 1'b0;
      pkt_available <= (qcount_next != '0);
      overload      <= overload_flag_next;
      timeout_fired <= fired;
      dropped       <= drop;
    end
  end

endmodule
